>>> design/hpl_pkg.sv
`timescale 1ns / 1ps

package hpl_pkg;

    // Buffer geometry
    localparam int BUFFER_BYTES = 512;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int FILL_W       = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W        = (FILL_W > 16) ? FILL_W : 16;
    localparam int HDR_BYTES    = 3;
    localparam int HDR_REGS     = 5;
    localparam int HIDX_W       = 3;
    localparam int MAX_LEN      = BUFFER_BYTES - HDR_BYTES;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Stream widths
    localparam int TDATA_IN_W  = 48;
    localparam int TUSER_IN_W  = 4;
    localparam int TDATA_OUT_W = 40;

    typedef logic [7:0]        byte_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [CMP_W-1:0]  cmp_t;
    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QCNT_W-1:0] qcnt_t;
    typedef logic [TDATA_OUT_W-1:0] out_data_t;

    // Action codes
    localparam logic [3:0] ACT_DIR_HIGH      = 4'd0;
    localparam logic [3:0] ACT_DIR_LOW       = 4'd1;
    localparam logic [3:0] ACT_BUS_BYTE      = 4'd2;
    localparam logic [3:0] ACT_SEND_ACK      = 4'd3;
    localparam logic [3:0] ACT_SET_BUSY      = 4'd4;
    localparam logic [3:0] ACT_READ_REQ      = 4'd5;
    localparam logic [3:0] ACT_READ_PAYLOAD  = 4'd6;
    localparam logic [3:0] ACT_WRITE_PAYLOAD = 4'd7;
    localparam logic [3:0] ACT_SEND          = 4'd8;

    // Link modes
    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_RECEIVING = 2'd1;
    localparam logic [1:0] MODE_RECEIVED  = 2'd2;
    localparam logic [1:0] MODE_SENDING   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NO_DATA    = 2'd0;
    localparam logic [1:0] CFG_PROTO_ERR  = 2'd1;
    localparam logic [1:0] CFG_BUSY       = 2'd2;

    localparam byte_t NO_DATA_RESET   = 8'd0;
    localparam byte_t PROTO_ERR_RESET = 8'd254;
    localparam byte_t BUSY_RESET      = 8'd253;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic [8:0] resp_length;
        byte_t      resp_type;
        byte_t      data_byte;
        logic [8:0] index;
        byte_t      bus_byte;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // Result item, last field in the lowest bits
    typedef struct packed {
        byte_t      payload_byte;
        logic [8:0] req_len;
        byte_t      req_type;
        logic       recv_ack;
        byte_t      send_data;
        logic       send_valid;
        logic       bus_drive;
        logic [1:0] link_mode;
    } result_t;

    // Result with the buffer byte still to be merged
    typedef struct packed {
        result_t res;
        logic    send_from_mem;
        logic    pay_from_mem;
    } desc_t;

    // Packet buffer access for one transaction
    typedef struct packed {
        logic  we;
        addr_t waddr;
        byte_t wdata;
        logic  re;
        addr_t raddr;
    } mem_cmd_t;

endpackage

>>> design/handshake_packet_link_core.sv
`timescale 1ns / 1ps

// Byte-wide handshake packet link. Each input transaction (an action in s_tuser) yields
// exactly one result transaction on the master side. The block takes one transaction per
// cycle while s_tready is high. The accepting edge registers the decoded result together
// with a read of the 512-byte packet buffer, which has one write and one read port. The
// next edge merges the read byte and writes the result into a four-entry queue, and
// m_tvalid is high whenever that queue holds a result. The queue lets the input keep
// running while the output stalls; s_tready drops only when that queue and the in-flight
// transaction fill it. No clearing pass follows reset. Configuration writes on the cfg
// channel are always taken and are meant to be issued while the link is idle.
module handshake_packet_link_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bus_byte[7:0], index[16:8], data_byte[24:17], resp_type[32:25],
    // resp_length[41:33], zero pad
    input  logic [hpl_pkg::TDATA_IN_W-1:0]     s_tdata,
    // action[3:0]
    input  logic [hpl_pkg::TUSER_IN_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // link_mode[1:0], bus_drive[2], send_valid[3], send_data[11:4], recv_ack[12],
    // req_type[20:13], req_len[29:21], payload_byte[37:30], zero pad
    output logic [hpl_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [7:0]                         cfg_data
);

    hpl_pkg::item_t    fields;
    hpl_pkg::mem_cmd_t mem_cmd;
    hpl_pkg::desc_t    desc;
    logic              desc_valid;
    logic              slot_free;
    hpl_pkg::byte_t    rd_data;
    hpl_pkg::result_t  out_res;

    assign fields    = hpl_pkg::item_t'(s_tdata[hpl_pkg::ITEM_W-1:0]);
    assign cfg_ready = 1'b1;

    hpl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (s_tuser),
        .fields     (fields),
        .slot_free  (slot_free),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mem_cmd    (mem_cmd),
        .desc       (desc),
        .desc_valid (desc_valid)
    );

    hpl_buffer u_buffer
    (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    hpl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .rd_data    (rd_data),
        .slot_free  (slot_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    // Pack the result with zero fill
    assign m_tdata = hpl_pkg::out_data_t'(out_res);

endmodule

>>> design/hpl_buffer.sv
`timescale 1ns / 1ps

// Packet buffer: one write port, one registered read port
module hpl_buffer
(
    input  logic              clk,
    input  hpl_pkg::mem_cmd_t cmd,
    output hpl_pkg::byte_t    rd_data
);

    hpl_pkg::byte_t mem [hpl_pkg::BUFFER_BYTES];
    hpl_pkg::byte_t rd_data_reg;

    // Write and read the store
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rd_data_reg <= mem[cmd.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/hpl_front.sv
`timescale 1ns / 1ps

// Front end: accept transactions, run the link state, issue buffer accesses
module hpl_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        action,
    input  hpl_pkg::item_t    fields,
    input  logic              slot_free,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  hpl_pkg::byte_t    cfg_data,
    output hpl_pkg::mem_cmd_t mem_cmd,
    output hpl_pkg::desc_t    desc,
    output logic              desc_valid
);

    logic [1:0]       mode_reg, mode_next;
    hpl_pkg::fill_t   fill_reg, fill_next;
    hpl_pkg::fill_t   spos_reg, spos_next;
    logic             busy_reg, busy_next;
    hpl_pkg::byte_t   hdr_reg  [hpl_pkg::HDR_REGS];
    hpl_pkg::byte_t   hdr_next [hpl_pkg::HDR_REGS];
    hpl_pkg::byte_t   no_data_reg, proto_err_reg, busy_code_reg;
    hpl_pkg::desc_t   desc_reg, desc_next;
    logic             desc_valid_reg;

    logic             accept;
    hpl_pkg::cmp_t    fill_w, spos_w, pos, rd_pos, wr_pos, claimed, len_w, rlen;
    hpl_pkg::byte_t   lo, hi, hdr_rd;
    logic             bad;
    logic             do_start;
    hpl_pkg::byte_t   st_type;
    hpl_pkg::cmp_t    st_len;
    logic             wr_en, wr_hdr;
    hpl_pkg::byte_t   wr_data;
    logic             rd_mem;

    assign accept   = in_valid & slot_free;
    assign in_ready = slot_free;

    // Decode one transaction and work out the next link state
    always_comb
    begin
        mode_next = mode_reg;
        fill_next = fill_reg;
        spos_next = spos_reg;
        busy_next = busy_reg;
        for (int i = 0; i < hpl_pkg::HDR_REGS; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        desc_next = '0;
        do_start  = 1'b0;
        st_type   = '0;
        st_len    = '0;
        wr_en     = 1'b0;
        wr_data   = '0;
        rd_mem    = 1'b0;

        fill_w = hpl_pkg::cmp_t'(fill_reg);
        spos_w = hpl_pkg::cmp_t'(spos_reg);
        pos    = hpl_pkg::cmp_t'(fields.index) + hpl_pkg::cmp_t'(hpl_pkg::HDR_BYTES);
        rd_pos = (action == hpl_pkg::ACT_SEND_ACK) ? spos_w : pos;
        wr_pos = (action == hpl_pkg::ACT_BUS_BYTE) ? fill_w : pos;
        hdr_rd = (rd_pos < hpl_pkg::cmp_t'(hpl_pkg::HDR_REGS))
                 ? hdr_reg[rd_pos[hpl_pkg::HIDX_W-1:0]] : '0;
        wr_hdr = wr_pos < hpl_pkg::cmp_t'(hpl_pkg::HDR_REGS);

        // Header check on direction low; missing length bytes count as zero
        lo      = (fill_w >= hpl_pkg::cmp_t'(2)) ? hdr_reg[1] : '0;
        hi      = (fill_w >= hpl_pkg::cmp_t'(3)) ? hdr_reg[2] : '0;
        claimed = hpl_pkg::cmp_t'({hi, lo});
        bad     = (fill_w < hpl_pkg::cmp_t'(hpl_pkg::HDR_BYTES))
                  || (claimed != fill_w - hpl_pkg::cmp_t'(hpl_pkg::HDR_BYTES))
                  || (hdr_reg[0] == '0);

        // Saturate the host response length
        rlen = (hpl_pkg::cmp_t'(fields.resp_length) > hpl_pkg::cmp_t'(hpl_pkg::MAX_LEN))
               ? hpl_pkg::cmp_t'(hpl_pkg::MAX_LEN) : hpl_pkg::cmp_t'(fields.resp_length);

        unique case (action)
            hpl_pkg::ACT_DIR_HIGH:
            begin
                mode_next = hpl_pkg::MODE_RECEIVING;
                fill_next = '0;
            end
            hpl_pkg::ACT_DIR_LOW:
            begin
                if (mode_reg == hpl_pkg::MODE_RECEIVING)
                begin
                    if (bad)
                    begin
                        hdr_next[3] = claimed[7:0];
                        hdr_next[4] = claimed[15:8];
                        do_start    = 1'b1;
                        st_type     = proto_err_reg;
                        st_len      = hpl_pkg::cmp_t'(2);
                    end
                    else if (busy_reg)
                    begin
                        do_start = 1'b1;
                        st_type  = busy_code_reg;
                        st_len   = '0;
                    end
                    else
                    begin
                        mode_next = hpl_pkg::MODE_RECEIVED;
                    end
                end
                else
                begin
                    mode_next = hpl_pkg::MODE_IDLE;
                end
            end
            hpl_pkg::ACT_BUS_BYTE:
            begin
                if (mode_reg == hpl_pkg::MODE_RECEIVING)
                begin
                    // Store while room remains, acknowledge always
                    if (fill_w < hpl_pkg::cmp_t'(hpl_pkg::BUFFER_BYTES))
                    begin
                        wr_en     = 1'b1;
                        wr_data   = fields.bus_byte;
                        fill_next = fill_reg + hpl_pkg::fill_t'(1);
                    end
                    desc_next.res.recv_ack = 1'b1;
                end
            end
            hpl_pkg::ACT_SEND_ACK:
            begin
                if (mode_reg == hpl_pkg::MODE_SENDING)
                begin
                    if ((spos_w < fill_w)
                        && (spos_w < hpl_pkg::cmp_t'(hpl_pkg::BUFFER_BYTES)))
                    begin
                        desc_next.res.send_valid = 1'b1;
                        if (spos_w < hpl_pkg::cmp_t'(hpl_pkg::HDR_REGS))
                        begin
                            desc_next.res.send_data = hdr_rd;
                        end
                        else
                        begin
                            rd_mem                  = 1'b1;
                            desc_next.send_from_mem = 1'b1;
                        end
                        spos_next = spos_reg + hpl_pkg::fill_t'(1);
                    end
                    else
                    begin
                        mode_next = hpl_pkg::MODE_IDLE;
                    end
                end
            end
            hpl_pkg::ACT_SET_BUSY:
            begin
                busy_next = fields.data_byte[0];
            end
            hpl_pkg::ACT_READ_PAYLOAD:
            begin
                if ((mode_reg == hpl_pkg::MODE_RECEIVED) && (pos < fill_w)
                    && (pos < hpl_pkg::cmp_t'(hpl_pkg::BUFFER_BYTES)))
                begin
                    if (pos < hpl_pkg::cmp_t'(hpl_pkg::HDR_REGS))
                    begin
                        desc_next.res.payload_byte = hdr_rd;
                    end
                    else
                    begin
                        rd_mem                 = 1'b1;
                        desc_next.pay_from_mem = 1'b1;
                    end
                end
            end
            hpl_pkg::ACT_WRITE_PAYLOAD:
            begin
                if (pos < hpl_pkg::cmp_t'(hpl_pkg::BUFFER_BYTES))
                begin
                    wr_en   = 1'b1;
                    wr_data = fields.data_byte;
                end
            end
            hpl_pkg::ACT_SEND:
            begin
                do_start = 1'b1;
                st_type  = fields.resp_type;
                st_len   = rlen;
            end
            hpl_pkg::ACT_READ_REQ:
            begin
                // Report only
            end
            default:
            begin
                // Unused codes leave the state alone
            end
        endcase

        // Mirror header-area writes into the header registers
        if (wr_en && wr_hdr)
        begin
            hdr_next[wr_pos[hpl_pkg::HIDX_W-1:0]] = wr_data;
        end

        // Build the header and put its first byte on the bus
        if (do_start)
        begin
            hdr_next[0] = st_type;
            hdr_next[1] = st_len[7:0];
            hdr_next[2] = st_len[15:8];
            fill_next   = hpl_pkg::fill_t'(st_len + hpl_pkg::cmp_t'(hpl_pkg::HDR_BYTES));
            spos_next   = hpl_pkg::fill_t'(1);
            mode_next   = hpl_pkg::MODE_SENDING;
            desc_next.res.send_valid = 1'b1;
            desc_next.res.send_data  = st_type;
        end

        // Report the state after the transaction
        desc_next.res.link_mode = mode_next;
        desc_next.res.bus_drive = (mode_next == hpl_pkg::MODE_SENDING);
        len_w = hpl_pkg::cmp_t'(fill_next) - hpl_pkg::cmp_t'(hpl_pkg::HDR_BYTES);
        if ((mode_next == hpl_pkg::MODE_RECEIVED)
            && (hpl_pkg::cmp_t'(fill_next) >= hpl_pkg::cmp_t'(hpl_pkg::HDR_BYTES)))
        begin
            desc_next.res.req_type = hdr_next[0];
            desc_next.res.req_len  = len_w[8:0];
        end
        else
        begin
            desc_next.res.req_type = no_data_reg;
            desc_next.res.req_len  = '0;
        end
    end

    // Buffer access for this transaction
    always_comb
    begin
        mem_cmd.we    = accept & wr_en;
        mem_cmd.waddr = wr_pos[hpl_pkg::ADDR_W-1:0];
        mem_cmd.wdata = wr_data;
        mem_cmd.re    = accept & rd_mem;
        mem_cmd.raddr = rd_pos[hpl_pkg::ADDR_W-1:0];
    end

    // Advance control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= hpl_pkg::MODE_IDLE;
            fill_reg       <= '0;
            spos_reg       <= '0;
            busy_reg       <= 1'b0;
            desc_valid_reg <= 1'b0;
            no_data_reg    <= hpl_pkg::NO_DATA_RESET;
            proto_err_reg  <= hpl_pkg::PROTO_ERR_RESET;
            busy_code_reg  <= hpl_pkg::BUSY_RESET;
        end
        else
        begin
            desc_valid_reg <= accept;
            if (accept)
            begin
                mode_reg <= mode_next;
                fill_reg <= fill_next;
                spos_reg <= spos_next;
                busy_reg <= busy_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    hpl_pkg::CFG_NO_DATA:   no_data_reg   <= cfg_data;
                    hpl_pkg::CFG_PROTO_ERR: proto_err_reg <= cfg_data;
                    hpl_pkg::CFG_BUSY:      busy_code_reg <= cfg_data;
                    default:
                    begin
                        // Drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // Hold header bytes and the outgoing descriptor
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < hpl_pkg::HDR_REGS; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
            desc_reg <= desc_next;
        end
    end

    assign desc       = desc_reg;
    assign desc_valid = desc_valid_reg;

endmodule

>>> design/hpl_back.sv
`timescale 1ns / 1ps

// Back end: merge buffer data into results and queue them for the output
module hpl_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_valid,
    input  hpl_pkg::desc_t   desc,
    input  hpl_pkg::byte_t   rd_data,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output hpl_pkg::result_t out_res
);

    hpl_pkg::result_t q_reg [hpl_pkg::QDEPTH];
    hpl_pkg::qptr_t   wr_ptr_reg, rd_ptr_reg;
    hpl_pkg::qcnt_t   count_reg, count_next;
    hpl_pkg::result_t merged;
    logic             push, pop;

    // Fill in the byte read from the buffer
    always_comb
    begin
        merged = desc.res;
        if (desc.send_from_mem)
        begin
            merged.send_data = rd_data;
        end
        if (desc.pay_from_mem)
        begin
            merged.payload_byte = rd_data;
        end
    end

    assign push      = desc_valid;
    assign pop       = out_valid & out_ready;
    assign out_valid = count_reg != '0;
    assign out_res   = q_reg[rd_ptr_reg];

    // Leave room for the transaction still in flight
    assign slot_free = (count_reg + hpl_pkg::qcnt_t'(desc_valid))
                       < hpl_pkg::qcnt_t'(hpl_pkg::QDEPTH);

    always_comb
    begin
        count_next = count_reg + hpl_pkg::qcnt_t'(push) - hpl_pkg::qcnt_t'(pop);
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + hpl_pkg::qptr_t'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + hpl_pkg::qptr_t'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store queued results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= merged;
        end
    end

endmodule

>>> bench/handshake_packet_link_core_tb.sv
`timescale 1ns / 1ps

module handshake_packet_link_core_tb;

    import hpl_pkg::*;

    // Track the link state and hold the results still owed by the block
    class link_tracker;
        byte_t       store [BUFFER_BYTES];
        int unsigned fill;
        int unsigned tx_pos;
        logic [1:0]  mode;
        bit          busy;
        byte_t       no_data;
        byte_t       proto_err;
        byte_t       busy_type;
        result_t     outcome;
        result_t     awaited_results [$];
        int unsigned taken;
        int unsigned checked;
        int unsigned failures;

        function new();
            foreach (store[i]) store[i] = '0;
            fill      = 0;
            tx_pos    = 0;
            mode      = MODE_IDLE;
            busy      = 1'b0;
            no_data   = NO_DATA_RESET;
            proto_err = PROTO_ERR_RESET;
            busy_type = BUSY_RESET;
            taken     = 0;
            checked   = 0;
            failures  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, byte_t value);
            case (idx)
                CFG_NO_DATA:   no_data   = value;
                CFG_PROTO_ERR: proto_err = value;
                CFG_BUSY:      busy_type = value;
                default: ;
            endcase
        endfunction

        // Build the header in place and put the type byte on the bus
        function void begin_send(byte_t typ, int unsigned len);
            if (len > MAX_LEN)
                len = MAX_LEN;
            store[0] = typ;
            store[1] = len[7:0];
            store[2] = len[15:8];
            fill     = len + HDR_BYTES;
            mode     = MODE_SENDING;
            tx_pos   = 1;
            outcome.send_valid = 1'b1;
            outcome.send_data  = typ;
        endfunction

        // Validate the received packet and pick the answer
        function void close_packet();
            int unsigned lo;
            int unsigned hi;
            int unsigned claimed;
            bit          bad;
            lo      = (fill >= 2) ? int'(store[1]) : 0;
            hi      = (fill >= 3) ? int'(store[2]) : 0;
            claimed = (hi << 8) | lo;
            bad     = (fill < HDR_BYTES) || (claimed != fill - HDR_BYTES) || (store[0] == 8'd0);
            if (bad)
            begin
                store[3] = claimed[7:0];
                store[4] = claimed[15:8];
                begin_send(proto_err, 2);
            end
            else if (busy)
                begin_send(busy_type, 0);
            else
                mode = MODE_RECEIVED;
        endfunction

        // Advance the link by one accepted transaction and queue its result
        function void take_action(logic [3:0] act, item_t it);
            int unsigned pos;
            outcome = '0;
            pos     = int'(it.index) + HDR_BYTES;
            case (act)
                ACT_DIR_HIGH:
                begin
                    mode = MODE_RECEIVING;
                    fill = 0;
                end
                ACT_DIR_LOW:
                begin
                    if (mode == MODE_RECEIVING)
                        close_packet();
                    else
                        mode = MODE_IDLE;
                end
                ACT_BUS_BYTE:
                begin
                    if (mode == MODE_RECEIVING)
                    begin
                        if (fill < BUFFER_BYTES)
                        begin
                            store[fill] = it.bus_byte;
                            fill++;
                        end
                        outcome.recv_ack = 1'b1;
                    end
                end
                ACT_SEND_ACK:
                begin
                    if (mode == MODE_SENDING)
                    begin
                        if (tx_pos < fill && tx_pos < BUFFER_BYTES)
                        begin
                            outcome.send_valid = 1'b1;
                            outcome.send_data  = store[tx_pos];
                            tx_pos++;
                        end
                        else
                            mode = MODE_IDLE;
                    end
                end
                ACT_SET_BUSY: busy = it.data_byte[0];
                ACT_READ_REQ: ;
                ACT_READ_PAYLOAD:
                begin
                    if (mode == MODE_RECEIVED && pos < fill && pos < BUFFER_BYTES)
                        outcome.payload_byte = store[pos];
                end
                ACT_WRITE_PAYLOAD:
                begin
                    if (pos < BUFFER_BYTES)
                        store[pos] = it.data_byte;
                end
                ACT_SEND: begin_send(it.resp_type, int'(it.resp_length));
                default: ;
            endcase
            outcome.link_mode = mode;
            outcome.bus_drive = (mode == MODE_SENDING);
            if (mode == MODE_RECEIVED && fill >= HDR_BYTES)
            begin
                outcome.req_type = store[0];
                outcome.req_len  = 9'(fill - HDR_BYTES);
            end
            else
            begin
                outcome.req_type = no_data;
                outcome.req_len  = '0;
            end
            awaited_results.push_back(outcome);
            taken++;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        task report_mismatch(string msg);
            failures++;
            if (failures <= 60)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                          checked, name, got, want));
        endtask

        // Compare one result transaction with the oldest one owed
        task match_result(out_data_t data);
            result_t got;
            result_t want;
            got = result_t'(data[$bits(result_t)-1:0]);
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result transaction with none outstanding");
                return;
            end
            want = awaited_results.pop_front();
            compare_field("link_mode", 16'(got.link_mode), 16'(want.link_mode));
            compare_field("bus_drive", 16'(got.bus_drive), 16'(want.bus_drive));
            compare_field("send_valid", 16'(got.send_valid), 16'(want.send_valid));
            compare_field("send_data", 16'(got.send_data), 16'(want.send_data));
            compare_field("recv_ack", 16'(got.recv_ack), 16'(want.recv_ack));
            compare_field("req_type", 16'(got.req_type), 16'(want.req_type));
            compare_field("req_len", 16'(got.req_len), 16'(want.req_len));
            compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
            checked++;
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic [TUSER_IN_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    link_tracker sb = new();

    bit          calm     = 1'b0;
    bit          busy_now = 1'b0;
    int unsigned sent     = 0;
    int unsigned settings = 1;

    handshake_packet_link_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the result side now and then, except in the calm stretch
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 11);

    // Record every accepted input transaction
    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
            sb.take_action(s_tuser, item_t'(s_tdata[ITEM_W-1:0]));

    // Check every accepted result transaction
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.match_result(m_tdata);

    // Track register writes
    always @(posedge clk)
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_reg(cfg_index, cfg_data);

    function automatic item_t random_fields();
        item_t f;
        f.bus_byte    = 8'($urandom);
        f.index       = 9'($urandom);
        f.data_byte   = 8'($urandom);
        f.resp_type   = 8'($urandom);
        f.resp_length = 9'($urandom);
        return f;
    endfunction

    // Present one transaction and hold it until accepted
    task automatic drive(input logic [3:0] act, input item_t it);
        if (!calm && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(TDATA_IN_W - ITEM_W){1'b0}}, it};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        if (act == ACT_SET_BUSY)
            busy_now = it.data_byte[0];
    endtask

    task automatic ack_run(input int unsigned n);
        repeat (n)
            drive(ACT_SEND_ACK, random_fields());
    endtask

    // Receive a packet of type, little-endian claim and payload, cut to total bytes
    task automatic rx_packet(input byte_t typ, input int unsigned claim,
                             input int unsigned total);
        item_t it;
        drive(ACT_DIR_HIGH, random_fields());
        for (int unsigned k = 0; k < total; k++)
        begin
            it = random_fields();
            if (k == 0)
                it.bus_byte = typ;
            else if (k == 1)
                it.bus_byte = claim[7:0];
            else if (k == 2)
                it.bus_byte = claim[15:8];
            drive(ACT_BUS_BYTE, it);
        end
        drive(ACT_DIR_LOW, random_fields());
    endtask

    // Write a response payload, start it and acknowledge it out to idle
    task automatic tx_response(input byte_t typ, input int unsigned len);
        item_t it;
        for (int unsigned k = 0; k < len; k++)
        begin
            it       = random_fields();
            it.index = 9'(k);
            drive(ACT_WRITE_PAYLOAD, it);
        end
        it             = random_fields();
        it.resp_type   = typ;
        it.resp_length = 9'(len);
        drive(ACT_SEND, it);
        ack_run(len + HDR_BYTES + $urandom_range(0, 1));
    endtask

    // Stop sending and wait for every owed result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic program_regs(input byte_t nd, input byte_t pe, input byte_t bz);
        byte_t      vals [3];
        logic [1:0] regs [3];
        vals = '{nd, pe, bz};
        regs = '{CFG_NO_DATA, CFG_PROTO_ERR, CFG_BUSY};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    // Mostly host exchanges, with broken packets, busy toggles and noise mixed in
    task automatic run_random(input int unsigned budget);
        int unsigned stop;
        int unsigned pick;
        int unsigned n;
        item_t       it;
        stop = sent + budget;
        while (sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
                rx_packet(8'($urandom_range(1, 255)), n, n + HDR_BYTES);
                if (busy_now)
                    ack_run(HDR_BYTES + $urandom_range(0, 1));
                else
                begin
                    drive(ACT_READ_REQ, random_fields());
                    repeat ($urandom_range(0, 4))
                    begin
                        it = random_fields();
                        if ($urandom_range(0, 4) != 0)
                            it.index = 9'($urandom_range(0, n + 1));
                        drive(ACT_READ_PAYLOAD, it);
                    end
                    tx_response(8'($urandom), $urandom_range(0, 10));
                end
            end
            else if (pick < 70)
            begin
                n = $urandom_range(0, 8);
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    rx_packet(8'($urandom), $urandom_range(0, 65535), $urandom_range(0, 2));
                else if (pick == 1)
                    rx_packet(8'd0, n, n + HDR_BYTES);
                else
                    rx_packet(8'($urandom_range(1, 255)), $urandom_range(0, 65535), n);
                ack_run(5 + $urandom_range(0, 1));
            end
            else if (pick < 75)
            begin
                it              = random_fields();
                it.data_byte[0] = ($urandom_range(0, 3) == 0);
                drive(ACT_SET_BUSY, it);
            end
            else
                drive(4'($urandom_range(0, 15)), random_fields());
        end
    endtask

    initial
    begin
        item_t it;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-buffer packet with overflow bytes; it also fills every store byte
        rx_packet(8'h5A, MAX_LEN, BUFFER_BYTES + 8);
        drive(ACT_READ_REQ, random_fields());
        it = random_fields(); it.index = 9'd0;   drive(ACT_READ_PAYLOAD, it);
        it = random_fields(); it.index = 9'd508; drive(ACT_READ_PAYLOAD, it);
        it = random_fields(); it.index = 9'd509; drive(ACT_READ_PAYLOAD, it);
        it = random_fields(); it.index = 9'd511; drive(ACT_READ_PAYLOAD, it);
        it = random_fields(); it.index = 9'd508; it.data_byte = 8'hFF;
        drive(ACT_WRITE_PAYLOAD, it);
        it = random_fields(); it.index = 9'd511; it.data_byte = 8'h00;
        drive(ACT_WRITE_PAYLOAD, it);
        // Dir low while a packet is held drops it
        drive(ACT_DIR_LOW, random_fields());
        // Oversized send saturates to the buffer; check its header, then drop it early
        it = random_fields(); it.resp_type = 8'hFF; it.resp_length = 9'h1FF;
        drive(ACT_SEND, it);
        ack_run(8);
        drive(ACT_DIR_LOW, random_fields());

        // Events that do nothing in idle, plus unused actions
        it = random_fields(); it.bus_byte = 8'hFF; drive(ACT_BUS_BYTE, it);
        drive(ACT_SEND_ACK, random_fields());
        drive(ACT_READ_PAYLOAD, random_fields());
        drive(ACT_READ_REQ, random_fields());
        drive(4'd9, random_fields());
        drive(4'd15, random_fields());

        // Short packets, with missing header bytes counted as zero
        rx_packet(8'h11, 0, 0);
        ack_run(5);
        rx_packet(8'h22, 0, 1);
        ack_run(5);
        rx_packet(8'h33, 16'h1234, 2);
        ack_run(5);
        // Zero type with a correct length
        rx_packet(8'h00, 1, 4);
        ack_run(5);
        // Busy answer, then clear busy with the other bits set
        it = random_fields(); it.data_byte = 8'h01; drive(ACT_SET_BUSY, it);
        rx_packet(8'h44, 2, 5);
        ack_run(4);
        it = random_fields(); it.data_byte = 8'hFE; drive(ACT_SET_BUSY, it);
        // Header-only packet held, read past its length, answer with an empty send
        rx_packet(8'hFF, 0, 3);
        it = random_fields(); it.index = 9'd0; drive(ACT_READ_PAYLOAD, it);
        it = random_fields(); it.resp_type = 8'h00; it.resp_length = 9'd0;
        drive(ACT_SEND, it);
        ack_run(4);
        // Dir high in the middle of a send restarts the receive
        it = random_fields(); it.resp_type = 8'h80; it.resp_length = 9'd4;
        drive(ACT_SEND, it);
        ack_run(2);
        drive(ACT_DIR_HIGH, random_fields());
        drive(ACT_DIR_LOW, random_fields());
        ack_run(6);
        drain();

        // Random traffic under several register settings
        program_regs(8'hFF, 8'h00, 8'hFF);
        run_random(200);
        drain();
        program_regs(8'h00, 8'hFF, 8'h00);
        calm = 1'b1;
        run_random(120);
        calm = 1'b0;
        run_random(80);
        drain();
        program_regs(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(200);
        drain();
        repeat (8)
            @(posedge clk);

        $display("Drove %0d input transactions under %0d register settings, full buffer included",
                 sb.taken, settings);
        $display("Compared %0d result transactions field by field", sb.checked);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("handshake_packet_link_core verification clean");
        else
            $display("handshake_packet_link_core verification failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("handshake_packet_link_core verification failed");
        $finish;
    end

endmodule
